// File: rtl/cdq_pkg.sv
// Shared types and codes for the circular deque.
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_REAR   = 3'd3;
    localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [2:0] KIND_PEEK_REAR  = 3'd5;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               now_empty;
        logic               now_full;
    } rsp_t;

endpackage

// File: rtl/circular_deque.sv
// Circular deque: top level with pointer control and slot memory.
//
// Usage:
//   The cmd channel takes one request per handshake (cmd_valid high and
//   cmd_stall low at a rising edge): a kind code and a 32-bit word. Kinds
//   push at front or rear, pop front or rear, or peek front or rear.
//   The rsp channel returns exactly one result per request, in order:
//   status (done, overflow, empty), the popped or peeked word (zero
//   otherwise), and the empty and full flags after the request.
// Timing:
//   A request is decoded and the pointers are updated in the cycle it is
//   accepted; the slot memory is read or written in that same edge. The
//   result passes through the FINISH state and is loaded into the output
//   register once that register is free, and rsp_valid then rises. While
//   in FINISH cmd_stall is high, so the next request waits for that load.
// Reset:
//   rst_n clears the pointers to slot 0 and marks the deque empty. Slot
//   contents are not cleared; every slot is written before it is read.
// Stall:
//   While rsp_stall holds a result, the next request is still accepted and
//   held at the memory output until the output register frees up.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  cdq_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_FINISH = 2'b10
    } state_t;

    typedef struct packed {
        logic [1:0] status;
        logic       is_read;
        logic       now_empty;
        logic       now_full;
    } pend_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic            empty_reg, empty_next;
    pend_t           pend_reg, pend_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_t            rsp_reg;

    logic signed [31:0] slots [DEPTH];
    logic signed [31:0] rdata_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;

    logic accept, out_free, load_out, full_now;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign load_out  = (state_reg == S_FINISH) && out_free;
    assign full_now  = !empty_reg && (wrap_inc(tail_reg) == head_reg);

    // Decode the request, move the pointers and pick the slot to touch.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = head_reg;
        pend_next  = pend_reg;
        if (accept)
        begin
            pend_next.status  = STATUS_DONE;
            pend_next.is_read = 1'b0;
            if (cmd.kind inside {KIND_PUSH_FRONT, KIND_PUSH_REAR})
            begin
                if (full_now)
                begin
                    pend_next.status = STATUS_OVERFLOW;
                end
                else if (empty_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    mem_we     = 1'b1;
                    mem_addr   = '0;
                end
                else if (cmd.kind == KIND_PUSH_FRONT)
                begin
                    head_next = wrap_dec(head_reg);
                    mem_we    = 1'b1;
                    mem_addr  = head_next;
                end
                else
                begin
                    tail_next = wrap_inc(tail_reg);
                    mem_we    = 1'b1;
                    mem_addr  = tail_next;
                end
            end
            else if (cmd.kind inside {KIND_POP_FRONT, KIND_POP_REAR,
                                      KIND_PEEK_FRONT, KIND_PEEK_REAR})
            begin
                if (empty_reg)
                begin
                    pend_next.status = STATUS_EMPTY;
                end
                else
                begin
                    pend_next.is_read = 1'b1;
                    mem_re            = 1'b1;
                    mem_addr = (cmd.kind inside {KIND_POP_FRONT, KIND_PEEK_FRONT})
                               ? head_reg : tail_reg;
                    if (cmd.kind inside {KIND_POP_FRONT, KIND_POP_REAR})
                    begin
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (cmd.kind == KIND_POP_FRONT)
                        begin
                            head_next = wrap_inc(head_reg);
                        end
                        else
                        begin
                            tail_next = wrap_dec(tail_reg);
                        end
                    end
                end
            end
            pend_next.now_empty = empty_next;
            pend_next.now_full  = !empty_next && (wrap_inc(tail_next) == head_next);
        end
    end

    // Sequence: accept, then hand the result to the output register.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the pending result fields and load the output register.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (load_out)
        begin
            rsp_reg.status    <= pend_reg.status;
            rsp_reg.data      <= pend_reg.is_read ? rdata_reg : 32'sd0;
            rsp_reg.now_empty <= pend_reg.now_empty;
            rsp_reg.now_full  <= pend_reg.now_full;
        end
    end

    // Slot memory: one port, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots[mem_addr] <= cmd.value;
        end
        if (mem_re)
        begin
            rdata_reg <= slots[mem_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_OVERFLOW |-> rsp.now_full && !rsp.now_empty)
        else $error("overflow reported while deque not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_EMPTY |-> rsp.now_empty)
        else $error("empty status while deque holds words");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.now_empty && rsp.now_full))
        else $error("deque flagged both empty and full");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> head_reg == '0 && tail_reg == '0)
        else $error("pointers off slot zero while empty");

    a_accept_finish: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_FINISH)
        else $error("accepted request not moved to finish");

endmodule
